// ===== rtl/b64sd_pkg.sv =====
// Package for the Base64 stream decoder: beat types, constants and symbol decode.
package b64sd_pkg;

    // Result queue sizing: one input beat pushes at most five results
    localparam int unsigned MAX_PUSH    = 5;
    localparam int unsigned QUEUE_DEPTH = 8;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned PUSH_W      = $clog2(MAX_PUSH + 1);

    localparam logic [7:0] PAD_CHAR    = 8'h3D;  // '='
    localparam logic [7:0] INVALID_SYM = 8'hFF;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last;
    } in_beat_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       end_of_stream;
        logic       error;
    } out_beat_t;

    // Open group: decoded 6-bit values (or INVALID_SYM), fill and error flag
    typedef struct packed {
        logic [2:0][7:0] vals;
        logic [1:0]      cnt;
        logic            err;
    } grp_t;

    typedef struct packed {
        grp_t            g;
        logic            emit;
        logic [2:0][7:0] bytes;
    } feed_t;

    typedef struct packed {
        out_beat_t [MAX_PUSH-1:0] item;
        logic [PUSH_W-1:0]        n;
    } push_list_t;

    // Map one ASCII code to its 6-bit value; both alphabets accepted
    function automatic logic [7:0] decode_symbol(input logic [7:0] c);
        logic [7:0] v;
        v = INVALID_SYM;
        if (c >= 8'h41 && c <= 8'h5A) begin          // A-Z
            v = c - 8'h41;
        end else if (c >= 8'h61 && c <= 8'h7A) begin // a-z
            v = c - 8'h61 + 8'd26;
        end else if (c >= 8'h30 && c <= 8'h39) begin // 0-9
            v = c - 8'h30 + 8'd52;
        end else if (c == 8'h2B || c == 8'h2D) begin // '+' or '-'
            v = 8'd62;
        end else if (c == 8'h2F || c == 8'h5F) begin // '/' or '_'
            v = 8'd63;
        end
        return v;
    endfunction

    function automatic logic [7:0] first_byte(input logic [7:0] a, input logic [7:0] b);
        return {a[5:0], b[5:4]};
    endfunction

    function automatic logic [7:0] second_byte(input logic [7:0] b, input logic [7:0] c);
        return {b[3:0], c[5:2]};
    endfunction

    function automatic logic [7:0] third_byte(input logic [7:0] c, input logic [7:0] d);
        return {c[1:0], d[5:0]};
    endfunction

endpackage

// ===== rtl/base64_stream_decoder_unit.sv =====
// Base64 stream decoder top level: character in, decoded bytes and end beat out.
//
// Usage: s_data carries one character and a last flag per beat on a valid/ready
// channel. m_data returns result beats: decoded bytes (byte_valid=1) and, once
// per stream, an end beat (end_of_stream=1) whose error bit flags a bad full
// group. Bytes sent before an error must be discarded downstream.
// Each accepted beat's results are registered into the result queue before
// they show on m_. Throughput: one character per cycle while s_ready is high; each
// accepted beat pushes 0 to 5 results into an 8-entry result queue that drains
// one beat per cycle while m_ready is high, and s_ready is high while the queue
// holds at most 3 results. Four characters give three bytes, so a steady stream
// runs at one character per cycle while m_ready stays high. The last beat of a
// stream may push up to 5 results and the input waits while those drain.
// Reset (aresetn low, synchronous) empties the queue and clears the group and
// hold-back state. When m_ready is low, results collect in the queue and the
// input stalls once the queue can no longer take a worst-case beat.
module base64_stream_decoder_unit (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  b64sd_pkg::in_beat_t   s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output b64sd_pkg::out_beat_t  m_data
);

    // Group state and the two held-back characters
    b64sd_pkg::grp_t   grp_reg, grp_next;
    logic [1:0][7:0]   held_reg, held_next;
    logic [1:0]        held_cnt_reg, held_cnt_next;

    // Result queue
    b64sd_pkg::out_beat_t [b64sd_pkg::QUEUE_DEPTH-1:0] q_reg;
    logic [b64sd_pkg::QPTR_W-1:0] rd_reg, rd_next, wr_reg, wr_next;
    logic [b64sd_pkg::QCNT_W-1:0] cnt_reg, cnt_next;

    b64sd_pkg::push_list_t push;
    logic                  s_fire, m_fire;

    // Feed one character into the open group; a full group is checked here
    function automatic b64sd_pkg::feed_t feed(input b64sd_pkg::grp_t g,
                                              input logic [7:0] ch);
        b64sd_pkg::feed_t r;
        logic [7:0]       v;
        logic             bad;
        r       = '0;
        r.g     = g;
        v       = b64sd_pkg::decode_symbol(ch);
        bad     = 1'b0;
        if (g.cnt != 2'd3) begin
            r.g.vals[g.cnt] = v;
            r.g.cnt         = g.cnt + 2'd1;
        end else begin
            bad = (g.vals[0] == b64sd_pkg::INVALID_SYM) ||
                  (g.vals[1] == b64sd_pkg::INVALID_SYM) ||
                  (g.vals[2] == b64sd_pkg::INVALID_SYM) ||
                  (v == b64sd_pkg::INVALID_SYM);
            r.g.cnt = 2'd0;
            if (bad) begin
                r.g.err = 1'b1;
            end else begin
                r.emit = !g.err;
            end
            r.bytes[0] = b64sd_pkg::first_byte(g.vals[0], g.vals[1]);
            r.bytes[1] = b64sd_pkg::second_byte(g.vals[1], g.vals[2]);
            r.bytes[2] = b64sd_pkg::third_byte(g.vals[2], v);
        end
        return r;
    endfunction

    // Append one result beat to the push list
    function automatic b64sd_pkg::push_list_t add(input b64sd_pkg::push_list_t l,
                                                  input b64sd_pkg::out_beat_t b);
        b64sd_pkg::push_list_t r;
        r = l;
        for (int j = 0; j < b64sd_pkg::MAX_PUSH; j++) begin
            if (l.n == b64sd_pkg::PUSH_W'(j)) begin
                r.item[j] = b;
            end
        end
        r.n = l.n + b64sd_pkg::PUSH_W'(1);
        return r;
    endfunction

    function automatic b64sd_pkg::out_beat_t byte_beat(input logic [7:0] d);
        b64sd_pkg::out_beat_t b;
        b               = '0;
        b.out_byte      = d;
        b.byte_valid    = 1'b1;
        return b;
    endfunction

    function automatic b64sd_pkg::push_list_t add_group(input b64sd_pkg::push_list_t l,
                                                        input b64sd_pkg::feed_t f);
        b64sd_pkg::push_list_t r;
        r = l;
        if (f.emit) begin
            r = add(r, byte_beat(f.bytes[0]));
            r = add(r, byte_beat(f.bytes[1]));
            r = add(r, byte_beat(f.bytes[2]));
        end
        return r;
    endfunction

    // Handshakes
    assign s_ready = (cnt_reg <= b64sd_pkg::QCNT_W'(b64sd_pkg::QUEUE_DEPTH -
                                                   b64sd_pkg::MAX_PUSH));
    assign s_fire  = s_valid && s_ready;
    assign m_valid = (cnt_reg != '0);
    assign m_fire  = m_valid && m_ready;
    assign m_data  = q_reg[rd_reg];

    // Per-beat decode: group update, padding strip, tail bytes and end beat
    always_comb begin
        b64sd_pkg::feed_t      f;
        b64sd_pkg::out_beat_t  eb;
        logic [2:0][7:0]       tail;
        logic [1:0]            keep;
        logic [1:0]            k;
        logic [7:0]            prev;

        grp_next      = grp_reg;
        held_next     = held_reg;
        held_cnt_next = held_cnt_reg;
        push          = '0;
        f             = '0;
        eb            = '0;
        tail          = '0;
        keep          = '0;
        k             = '0;
        prev          = '0;

        if (s_fire) begin
            if (!s_data.last) begin
                if (held_cnt_reg == 2'd2) begin
                    f            = feed(grp_reg, held_reg[0]);
                    grp_next     = f.g;
                    push         = add_group(push, f);
                    held_next[0] = held_reg[1];
                    held_next[1] = s_data.char_code;
                end else begin
                    held_next[held_cnt_reg[0]] = s_data.char_code;
                    held_cnt_next              = held_cnt_reg + 2'd1;
                end
            end else begin
                grp_next = grp_reg;
                // A stream of one character skips straight to the end beat
                if (held_cnt_reg != 2'd0) begin
                    tail[0] = held_reg[0];
                    tail[1] = (held_cnt_reg == 2'd2) ? held_reg[1] : s_data.char_code;
                    tail[2] = s_data.char_code;
                    k       = held_cnt_reg + 2'd1;
                    prev    = (held_cnt_reg == 2'd2) ? held_reg[1] : held_reg[0];
                    keep    = k;
                    if (s_data.char_code == b64sd_pkg::PAD_CHAR) begin
                        keep = (prev == b64sd_pkg::PAD_CHAR) ? k - 2'd2 : k - 2'd1;
                    end
                    for (int i = 0; i < 3; i++) begin
                        if (2'(i) < keep) begin
                            f        = feed(grp_next, tail[i]);
                            grp_next = f.g;
                            push     = add_group(push, f);
                        end
                    end
                    // Tail of two or three characters
                    if (!grp_next.err && grp_next.cnt >= 2'd2) begin
                        push = add(push, byte_beat(
                            b64sd_pkg::first_byte(grp_next.vals[0], grp_next.vals[1])));
                        if (grp_next.cnt == 2'd3) begin
                            push = add(push, byte_beat(
                                b64sd_pkg::second_byte(grp_next.vals[1],
                                                       grp_next.vals[2])));
                        end
                    end
                end
                eb.end_of_stream = 1'b1;
                eb.error         = grp_next.err;
                push             = add(push, eb);
                grp_next.cnt     = 2'd0;
                grp_next.err     = 1'b0;
                held_cnt_next    = 2'd0;
            end
        end
    end

    // Queue pointers and fill
    always_comb begin
        wr_next  = wr_reg + b64sd_pkg::QPTR_W'(push.n);
        rd_next  = rd_reg + b64sd_pkg::QPTR_W'(m_fire);
        cnt_next = cnt_reg + b64sd_pkg::QCNT_W'(push.n) - b64sd_pkg::QCNT_W'(m_fire);
    end

    // Group state, hold-back count and queue pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grp_reg      <= '0;
            held_cnt_reg <= 2'd0;
            rd_reg       <= '0;
            wr_reg       <= '0;
            cnt_reg      <= '0;
        end else begin
            grp_reg      <= grp_next;
            held_cnt_reg <= held_cnt_next;
            rd_reg       <= rd_next;
            wr_reg       <= wr_next;
            cnt_reg      <= cnt_next;
        end
    end

    // Payload registers: held characters, queue entries
    always_ff @(posedge aclk) begin
        held_reg     <= held_next;
        for (int i = 0; i < b64sd_pkg::MAX_PUSH; i++) begin
            if (b64sd_pkg::PUSH_W'(i) < push.n) begin
                q_reg[wr_reg + b64sd_pkg::QPTR_W'(i)] <= push.item[i];
            end
        end
    end

    // Checks
    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= b64sd_pkg::QCNT_W'(b64sd_pkg::QUEUE_DEPTH))
        else $error("result queue overfilled");

    a_push_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        push.n <= b64sd_pkg::PUSH_W'(b64sd_pkg::MAX_PUSH))
        else $error("too many results pushed for one beat");

    a_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_data.last) |=>
            (held_cnt_reg == 2'd0 && grp_reg.cnt == 2'd0 && !grp_reg.err))
        else $error("stream state not cleared after end beat");

    a_no_bytes_after_error: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && !s_data.last && grp_reg.err) |-> (push.n == '0))
        else $error("bytes pushed after a bad group");

    a_end_not_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.byte_valid && m_data.end_of_stream))
        else $error("end beat marked as byte");

endmodule

// ===== bench/tb_base64_stream_decoder_unit.sv =====
// Self-checking testbench for the Base64 stream decoder: directed table, then random streams.
module tb_base64_stream_decoder_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [7:0] PAD     = b64sd_pkg::PAD_CHAR;
    localparam logic [7:0] BAD_SYM = b64sd_pkg::INVALID_SYM;
    localparam int QUIET_LIMIT     = 5000;
    localparam int DRAIN_CYCLES    = 20;
    localparam int PHASE_CHARS     = 70;

    // One row of the directed table; typed rows carry their end beat's error bit
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       typed;
        logic       err;
    } dir_row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    b64sd_pkg::in_beat_t  s_data;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    b64sd_pkg::out_beat_t m_data;

    // Side info that rides along with the beat on s_data
    logic row_typed;
    logic row_err;

    int gap_pct;
    int stall_pct;
    int fail_count;
    int quiet_cycles;

    // Decoder state mirror
    logic [7:0] grp_v [3];
    logic [1:0] grp_n;
    logic [7:0] held [2];
    logic [1:0] held_n;
    logic       err_seen;
    logic [1:0] seen_n;

    b64sd_pkg::out_beat_t decoded_q [$];
    logic [7:0]           stream_chars [$];

    dir_row_t dir_rows [0:24] = '{
        // single character: end beat only
        '{"A", 1'b1, 1'b1, 1'b0},
        // plain full group, "Man"
        '{"T", 1'b0, 1'b0, 1'b0}, '{"W", 1'b0, 1'b0, 1'b0},
        '{"F", 1'b0, 1'b0, 1'b0}, '{"u", 1'b1, 1'b0, 1'b0},
        // two trailing pads, one byte
        '{"T", 1'b0, 1'b0, 1'b0}, '{"Q", 1'b0, 1'b0, 1'b0},
        '{"=", 1'b0, 1'b0, 1'b0}, '{"=", 1'b1, 1'b0, 1'b0},
        // pad inside a full group is an error
        '{"A", 1'b0, 1'b0, 1'b0}, '{"=", 1'b0, 1'b0, 1'b0},
        '{"A", 1'b0, 1'b0, 1'b0}, '{"A", 1'b1, 1'b1, 1'b1},
        // both spellings of 62 and 63
        '{"-", 1'b0, 1'b0, 1'b0}, '{"_", 1'b0, 1'b0, 1'b0},
        '{"+", 1'b0, 1'b0, 1'b0}, '{"/", 1'b1, 1'b0, 1'b0},
        // code extremes in a full group: error
        '{8'hFF, 1'b0, 1'b0, 1'b0}, '{8'h00, 1'b0, 1'b0, 1'b0},
        '{"z", 1'b0, 1'b0, 1'b0}, '{"9", 1'b1, 1'b1, 1'b1},
        // invalid tail char is decoded unchecked
        '{"A", 1'b0, 1'b0, 1'b0}, '{"*", 1'b1, 1'b0, 1'b0},
        // only pads: nothing but the end beat
        '{"=", 1'b0, 1'b0, 1'b0}, '{"=", 1'b1, 1'b1, 1'b0}
    };

    int gap_tab   [4] = '{0, 65, 0, 35};
    int stall_tab [4] = '{0, 0, 65, 35};

    base64_stream_decoder_unit dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Receiver back-pressure
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    // 6-bit value of a character, 0xFF outside both alphabets
    function automatic logic [7:0] b64_value(input logic [7:0] c);
        logic [7:0] v;
        v = BAD_SYM;
        if (c >= "A" && c <= "Z")      v = c - "A";
        else if (c >= "a" && c <= "z") v = c - "a" + 8'd26;
        else if (c >= "0" && c <= "9") v = c - "0" + 8'd52;
        else if (c == "+" || c == "-") v = 8'd62;
        else if (c == "/" || c == "_") v = 8'd63;
        return v;
    endfunction

    // Character for a 6-bit value, picking either alphabet for 62 and 63
    function automatic logic [7:0] b64_char(input int v);
        logic [7:0] c;
        if (v < 26)      c = 8'("A" + v);
        else if (v < 52) c = 8'("a" + (v - 26));
        else if (v < 62) c = 8'("0" + (v - 52));
        else if (v == 62) c = $urandom_range(1) ? "+" : "-";
        else              c = $urandom_range(1) ? "/" : "_";
        return c;
    endfunction

    function automatic b64sd_pkg::out_beat_t byte_beat(input logic [7:0] b);
        return {b, 1'b1, 1'b0, 1'b0};
    endfunction

    // Append one expected beat at the tail of the scoreboard
    function automatic void queue_beat(input b64sd_pkg::out_beat_t b);
        decoded_q = {decoded_q, b};
    endfunction

    function automatic logic [7:0] byte_ab(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] r;
        r = (a << 2) | ((b & 8'h30) >> 4);
        return r;
    endfunction

    function automatic logic [7:0] byte_bc(input logic [7:0] b, input logic [7:0] c);
        logic [7:0] r;
        r = ((b & 8'h0F) << 4) | ((c & 8'h3C) >> 2);
        return r;
    endfunction

    function automatic logic [7:0] byte_cd(input logic [7:0] c, input logic [7:0] d);
        logic [7:0] r;
        r = ((c & 8'h03) << 6) | d;
        return r;
    endfunction

    task automatic clear_decoder();
        grp_v    = '{8'h00, 8'h00, 8'h00};
        grp_n    = 2'd0;
        held     = '{8'h00, 8'h00};
        held_n   = 2'd0;
        err_seen = 1'b0;
        seen_n   = 2'd0;
    endtask

    // Add one character to the open group; a full group decodes or flags error
    task automatic feed_group(input logic [7:0] ch);
        logic [7:0] v;
        v = b64_value(ch);
        if (grp_n < 2'd3) begin
            grp_v[grp_n] = v;
            grp_n = grp_n + 2'd1;
        end else begin
            grp_n = 2'd0;
            if (grp_v[0] == BAD_SYM || grp_v[1] == BAD_SYM || grp_v[2] == BAD_SYM ||
                v == BAD_SYM) begin
                err_seen = 1'b1;
            end else if (!err_seen) begin
                queue_beat(byte_beat(byte_ab(grp_v[0], grp_v[1])));
                queue_beat(byte_beat(byte_bc(grp_v[1], grp_v[2])));
                queue_beat(byte_beat(byte_cd(grp_v[2], v)));
            end
        end
    endtask

    // Expected results for one accepted character beat
    task automatic decode_char(input logic [7:0] ch, input logic lst);
        logic [7:0] tl [3];
        int k;
        int keep;
        if (seen_n < 2'd3) seen_n = seen_n + 2'd1;
        if (!lst) begin
            if (held_n >= 2'd2) begin
                feed_group(held[0]);
                held[0] = held[1];
                held[1] = ch;
            end else begin
                held[held_n[0]] = ch;
                held_n = held_n + 2'd1;
            end
        end else begin
            if (seen_n >= 2'd2) begin
                k = 0;
                for (int i = 0; i < held_n; i++) begin
                    tl[k] = held[i];
                    k++;
                end
                tl[k] = ch;
                k++;
                // trailing pads are dropped only at stream end
                keep = k;
                if (k >= 2 && tl[k-1] == PAD) begin
                    keep = k - 1;
                    if (tl[k-2] == PAD) keep = k - 2;
                end
                for (int i = 0; i < keep; i++) feed_group(tl[i]);
                if (!err_seen && grp_n >= 2'd2) begin
                    queue_beat(byte_beat(byte_ab(grp_v[0], grp_v[1])));
                    if (grp_n >= 2'd3)
                        queue_beat(byte_beat(byte_bc(grp_v[1], grp_v[2])));
                end
            end
            queue_beat({8'h00, 1'b0, 1'b1, err_seen});
            clear_decoder();
        end
    endtask

    task automatic note_fail(input b64sd_pkg::out_beat_t want,
                             input b64sd_pkg::out_beat_t got, input logic none);
        fail_count++;
        if (fail_count <= 10) begin
            if (none)
                $display("%0t unexpected beat: byte=%02h bv=%b eos=%b err=%b", $realtime,
                         got.out_byte, got.byte_valid, got.end_of_stream, got.error);
            else
                $display("%0t mismatch: exp %02h/%b/%b/%b got %02h/%b/%b/%b",
                         $realtime, want.out_byte, want.byte_valid, want.end_of_stream,
                         want.error, got.out_byte, got.byte_valid, got.end_of_stream,
                         got.error);
        end
    endtask

    // Check results, predict on accepted beats, watch for a hang
    always @(posedge aclk) begin
        b64sd_pkg::out_beat_t want;
        int n0;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (decoded_q.size() == 0) begin
                    note_fail(m_data, m_data, 1'b1);
                end else begin
                    want = decoded_q.pop_front();
                    if (m_data.out_byte !== want.out_byte ||
                        m_data.byte_valid !== want.byte_valid ||
                        m_data.end_of_stream !== want.end_of_stream ||
                        m_data.error !== want.error)
                        note_fail(want, m_data, 1'b0);
                end
            end
            if (s_valid && s_ready) begin
                n0 = decoded_q.size();
                decode_char(s_data.char_code, s_data.last);
                // typed rows replace the predicted end beat with the table's
                if (row_typed) begin
                    while (decoded_q.size() > n0) void'(decoded_q.pop_back());
                    queue_beat({8'h00, 1'b0, 1'b1, row_err});
                end
            end
            if ((m_valid && m_ready) || (s_valid && s_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= QUIET_LIMIT) begin
                    $display("FAILURE");
                    $finish;
                end
            end
        end
    end

    // Drive one character beat, with random idle cycles ahead of it
    task automatic send_char(input logic [7:0] ch, input logic lst, input logic typed,
                             input logic terr);
        if ($urandom_range(99) < gap_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < gap_pct);
        end
        s_valid   <= 1'b1;
        s_data    <= {ch, lst};
        row_typed <= typed;
        row_err   <= terr;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Mostly well-formed encoded streams; some with one char broken, some pure noise
    task automatic build_stream();
        int roll;
        int groups;
        int tail_bytes;
        int pos;
        logic [7:0] c;
        stream_chars.delete();
        roll = $urandom_range(9);
        if (roll >= 8) begin
            repeat ($urandom_range(1, 9)) begin
                c = 8'($urandom_range(255));
                stream_chars = {stream_chars, c};
            end
        end else begin
            groups     = $urandom_range(0, 4);
            tail_bytes = $urandom_range(0, 2);
            repeat (groups * 4) stream_chars = {stream_chars, b64_char($urandom_range(63))};
            if (tail_bytes > 0) begin
                repeat (tail_bytes + 1)
                    stream_chars = {stream_chars, b64_char($urandom_range(63))};
                if ($urandom_range(1))
                    repeat (3 - tail_bytes) stream_chars = {stream_chars, PAD};
            end
            if (stream_chars.size() == 0)
                stream_chars = {stream_chars, b64_char($urandom_range(63))};
            if (roll >= 6) begin
                pos = $urandom_range(stream_chars.size() - 1);
                c = 8'($urandom_range(255));
                stream_chars[pos] = $urandom_range(1) ? PAD : c;
            end
        end
    endtask

    initial begin
        int sent;
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_data       = '0;
        row_typed    = 1'b0;
        row_err      = 1'b0;
        gap_pct      = 0;
        stall_pct    = 0;
        fail_count   = 0;
        quiet_cycles = 0;
        clear_decoder();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table, no idling
        foreach (dir_rows[i])
            send_char(dir_rows[i].ch, dir_rows[i].last, dir_rows[i].typed, dir_rows[i].err);

        // random streams over the idling phases
        for (int ph = 0; ph < 4; ph++) begin
            gap_pct   = gap_tab[ph];
            stall_pct = stall_tab[ph];
            sent = 0;
            while (sent < PHASE_CHARS) begin
                build_stream();
                foreach (stream_chars[i])
                    send_char(stream_chars[i], i == stream_chars.size() - 1, 1'b0, 1'b0);
                sent += stream_chars.size();
            end
        end
        s_valid <= 1'b0;

        // drain; the watchdog bounds this wait
        while (decoded_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
